// ===== src/ap2d_pkg.sv =====
// Shared types, widths and codes for the 2-D average pooling block.
// No dependencies; imported by the top level and the divider.
package ap2d_pkg;

  // Field and register widths fixed by the interface
  localparam int POS_W     = 6;
  localparam int CH_W      = 4;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int DIM_W     = 7;
  localparam int SMALL_W   = 5;

  // Datapath widths: window origin plus offset, kernel area, window sum
  localparam int COORD_W = 11;
  localparam int PROD_W  = 10;
  localparam int SUM_W   = 26;
  localparam int MAG_W   = 25;
  localparam int NUM_W   = 26;
  localparam int DEN_W   = 11;
  localparam int CNT_W   = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_W  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_H  = 3'd6;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_TAIL,
    ST_LAUNCH,
    ST_DIV,
    ST_HOLD
  } state_t;

  // Clamp a register value to 1..hi
  function automatic logic [CFG_W-1:0] sat_cfg(input logic [CFG_W-1:0] v,
                                               input int unsigned hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > hi) begin
      r = CFG_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/ap2d_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ap2d_ram #(
  parameter int              WIDTH = 16,
  parameter longint unsigned DEPTH = 1024,
  localparam int             AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ap2d_div.sv =====
// Rounding divider: (2|sum| + d) / 2d, one quotient bit per cycle, sign restored.
// Depends on ap2d_pkg.
module ap2d_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ap2d_pkg::SUM_W-1:0]   sum,
  input  logic [ap2d_pkg::PROD_W-1:0]         area,
  output logic                                done,
  output logic signed [ap2d_pkg::SAMPLE_W-1:0] avg
);
  import ap2d_pkg::*;

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [NUM_W-1:0]     num_sh;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic                 neg;

  logic [SUM_W-1:0]     abs_sum;
  logic [NUM_W-1:0]     num_init;
  logic [DEN_W:0]       rem_sh;
  logic                 ge;
  logic [DEN_W:0]       rem_sub;
  logic [SAMPLE_W-1:0]  q_mag;

  assign abs_sum  = sum[SUM_W-1] ? -sum : sum;
  assign num_init = NUM_W'({abs_sum[MAG_W-1:0], 1'b0}) + NUM_W'(area);

  assign rem_sh  = {rem, num_sh[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  assign q_mag = num_sh[SAMPLE_W-1:0];
  assign avg   = neg ? -q_mag : q_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num_init;
      rem    <= '0;
      den    <= {area, 1'b0};
      neg    <= sum[SUM_W-1];
    end else if (busy) begin
      rem    <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_sh <= {num_sh[NUM_W-2:0], ge};
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_time: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(NUM_W + 1) done)
    else $error("divider result late or early");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider busy while reporting done");

endmodule

// ===== src/avg_pool_2d_edge_clamp.sv =====
// Top level of the 2-D average pooling block with edge clamping.
// Depends on ap2d_pkg, ap2d_ram and ap2d_div.
//
// A store beat is written straight into the map memory when it is taken; it
// gives no result. A query is taken and range-checked, then its window is walked
// one tap per cycle through the single read port of the map memory, the last
// read is drained and the sum launched into the bit-serial rounding divider, and
// the result is handed to the output register. One item is worked on at a time;
// the output register lets the next item in while a result still waits. The map
// memory is not cleared: a query may only touch entries that have been stored.
// Out-of-range queries answer with status 1 and average 0.
module avg_pool_2d_edge_clamp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_CH     = 16,
  parameter int MAX_KERNEL = 16,
  parameter int MAX_STRIDE = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 mode,
  input  logic [ap2d_pkg::POS_W-1:0]           pos_x,
  input  logic [ap2d_pkg::POS_W-1:0]           pos_y,
  input  logic [ap2d_pkg::CH_W-1:0]            channel,
  input  logic signed [ap2d_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ap2d_pkg::SAMPLE_W-1:0] average,
  output logic                                 status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ap2d_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ap2d_pkg::CFG_W-1:0]           cfg_data
);
  import ap2d_pkg::*;

  localparam longint unsigned DEPTH =
    longint'(MAX_WIDTH) * longint'(MAX_HEIGHT) * longint'(MAX_CH);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration, held already clamped to its legal range
  logic [DIM_W-1:0]   iw, ih;
  logic [SMALL_W-1:0] nc, sx, sy, kw, kh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iw <= sat_cfg(7'd64, MAX_WIDTH);
      ih <= sat_cfg(7'd64, MAX_HEIGHT);
      nc <= SMALL_W'(sat_cfg(7'd16, MAX_CH));
      sx <= SMALL_W'(sat_cfg(7'd2, MAX_STRIDE));
      sy <= SMALL_W'(sat_cfg(7'd2, MAX_STRIDE));
      kw <= SMALL_W'(sat_cfg(7'd2, MAX_KERNEL));
      kh <= SMALL_W'(sat_cfg(7'd2, MAX_KERNEL));
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IN_WIDTH:  iw <= sat_cfg(cfg_data, MAX_WIDTH);
        REG_IN_HEIGHT: ih <= sat_cfg(cfg_data, MAX_HEIGHT);
        REG_CHANNELS:  nc <= SMALL_W'(sat_cfg({2'b00, cfg_data[4:0]}, MAX_CH));
        REG_STRIDE_X:  sx <= SMALL_W'(sat_cfg({2'b00, cfg_data[4:0]}, MAX_STRIDE));
        REG_STRIDE_Y:  sy <= SMALL_W'(sat_cfg({2'b00, cfg_data[4:0]}, MAX_STRIDE));
        REG_KERNEL_W:  kw <= SMALL_W'(sat_cfg({2'b00, cfg_data[4:0]}, MAX_KERNEL));
        REG_KERNEL_H:  kh <= SMALL_W'(sat_cfg({2'b00, cfg_data[4:0]}, MAX_KERNEL));
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]   iwm1, ihm1;
  logic [SMALL_W-1:0] kwm1, khm1;
  logic [PROD_W-1:0]  area;

  assign iwm1 = iw - DIM_W'(1);
  assign ihm1 = ih - DIM_W'(1);
  assign kwm1 = kw - SMALL_W'(1);
  assign khm1 = kh - SMALL_W'(1);
  assign area = PROD_W'(kw) * PROD_W'(kh);

  state_t state, state_next;

  logic in_acc, out_free, store_ok;
  logic ram_we, walk, launch, load_out;
  logic rd_pend;
  logic div_done;
  logic signed [SAMPLE_W-1:0] div_avg;
  logic [SAMPLE_W-1:0]        rd_data;
  logic [ADDR_W-1:0]          waddr, raddr;

  // Query working registers
  logic [COORD_W-1:0]       bx, by, cx, cy;
  logic [CH_W-1:0]          qch;
  logic [SMALL_W-1:0]       kx, ky;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SAMPLE_W-1:0] res_avg;
  logic                     res_status;

  logic [DIM_W-1:0] ix, iy;
  logic             in_range, last_tap;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign store_ok = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT) &&
                    (32'(channel) < MAX_CH);
  assign ram_we   = in_acc && (mode == MODE_STORE) && store_ok;
  assign waddr    = (ADDR_W'(pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pos_x)) *
                    ADDR_W'(MAX_CH) + ADDR_W'(channel);

  // Clamp window coordinates to the last column and row
  assign ix = (cx > COORD_W'(iwm1)) ? iwm1 : cx[DIM_W-1:0];
  assign iy = (cy > COORD_W'(ihm1)) ? ihm1 : cy[DIM_W-1:0];
  assign raddr = (ADDR_W'(iy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ix)) *
                 ADDR_W'(MAX_CH) + ADDR_W'(qch);

  // px < ow is the same as px*sx <= in_width-1
  assign in_range = (bx <= COORD_W'(iwm1)) && (by <= COORD_W'(ihm1)) &&
                    (SMALL_W'(qch) < nc);
  assign last_tap = (kx == kwm1) && (ky == khm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_acc && mode == MODE_QUERY) state_next = ST_CHECK;
      ST_CHECK:  state_next = in_range ? ST_WALK : ST_HOLD;
      ST_WALK:   if (last_tap) state_next = ST_TAIL;
      ST_TAIL:   state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_HOLD;
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    walk     = (state == ST_WALK);
    launch   = (state == ST_LAUNCH);
    load_out = (state == ST_HOLD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= walk;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && mode == MODE_QUERY) begin
      bx  <= COORD_W'(pos_x) * COORD_W'(sx);
      by  <= COORD_W'(pos_y) * COORD_W'(sy);
      qch <= channel;
    end
    if (state == ST_CHECK) begin
      kx  <= '0;
      ky  <= '0;
      cx  <= bx;
      cy  <= by;
      acc <= '0;
      if (!in_range) begin
        res_avg    <= '0;
        res_status <= STATUS_RANGE;
      end
    end
    if (walk) begin
      // Advance along the row, then wrap to the next row
      if (kx == kwm1) begin
        kx <= '0;
        cx <= bx;
        ky <= ky + SMALL_W'(1);
        cy <= cy + COORD_W'(1);
      end else begin
        kx <= kx + SMALL_W'(1);
        cx <= cx + COORD_W'(1);
      end
    end
    if (rd_pend) begin
      acc <= acc + {{(SUM_W - SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
    end
    if (state == ST_DIV && div_done) begin
      res_avg    <= div_avg;
      res_status <= STATUS_OK;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average <= res_avg;
      status  <= res_status;
    end
  end

  ap2d_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (sample),
    .re    (walk),
    .raddr (raddr),
    .rdata (rd_data)
  );

  ap2d_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (launch),
    .sum   (acc),
    .area  (area),
    .done  (div_done),
    .avg   (div_avg)
  );

  a_pend: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state) == ST_WALK)
    else $error("read data returned outside a window walk");
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_RANGE |-> average == '0)
    else $error("range error beat carries a non-zero average");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_HOLD && !out_free |=> state == ST_HOLD)
    else $error("result dropped while output register full");
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !rd_pend && !walk)
    else $error("store written during a window walk");

endmodule

// ===== tb/tb_avg_pool_2d_edge_clamp.sv =====
// Self-checking testbench for avg_pool_2d_edge_clamp: stores and pooled queries, checked
// against an in-bench window-average predictor over several register settings.
// Depends on ap2d_pkg and the avg_pool_2d_edge_clamp RTL.
`timescale 1ns / 1ps

module tb_avg_pool_2d_edge_clamp;
  import ap2d_pkg::*;

  localparam int MAP_W     = 64;
  localparam int MAP_H     = 64;
  localparam int MAP_CH    = 16;
  localparam int MAP_DEPTH = MAP_W * MAP_H * MAP_CH;
  localparam int STEP_MAX  = 16;
  localparam int SETTLE    = 40;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [CFG_W-1:0] DIM_MASK   = CFG_W'((1 << DIM_W) - 1);
  localparam logic [CFG_W-1:0] SMALL_MASK = CFG_W'((1 << SMALL_W) - 1);

  typedef struct {
    logic                mode;
    logic [POS_W-1:0]    x;
    logic [POS_W-1:0]    y;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] smp;
  } pool_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    logic                       status;
  } pool_result_t;

  typedef struct {
    int unsigned iw, ih, nc, sx, sy, kw, kh, ow, oh;
  } pool_geom_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_STORE;
  logic [POS_W-1:0] pos_x = '0;
  logic [POS_W-1:0] pos_y = '0;
  logic [CH_W-1:0] channel = '0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] average;
  logic status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [SAMPLE_W-1:0] pix_mem [0:MAP_DEPTH-1];
  logic [CFG_W-1:0] model_cfg [0:7] = '{7'd64, 7'd64, 7'd16, 7'd2, 7'd2, 7'd2, 7'd2, 7'd0};
  pool_geom_t model_geom;
  pool_result_t awaited_averages[$];

  // stimulus state
  bit stored_flag [0:MAP_DEPTH-1];
  pool_item_t item_queue[$];
  pool_item_t cur;
  bit beat_taken = 1'b0;
  bit calm = 1'b0;
  int in_gap = 0;
  int stall_len = 0;
  int mismatches = 0;
  pool_result_t want;
  int ph;

  avg_pool_2d_edge_clamp DUT (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int unsigned clip_reg(input logic [CFG_W-1:0] raw,
                                           input logic [CFG_W-1:0] mask,
                                           input int unsigned hi);
    int unsigned v;
    v = raw & mask;
    if (v == 0) begin
      v = 1;
    end else if (v > hi) begin
      v = hi;
    end
    return v;
  endfunction

  function automatic pool_geom_t current_geom();
    pool_geom_t g;
    g.iw = clip_reg(model_cfg[REG_IN_WIDTH], DIM_MASK, MAP_W);
    g.ih = clip_reg(model_cfg[REG_IN_HEIGHT], DIM_MASK, MAP_H);
    g.nc = clip_reg(model_cfg[REG_CHANNELS], SMALL_MASK, MAP_CH);
    g.sx = clip_reg(model_cfg[REG_STRIDE_X], SMALL_MASK, STEP_MAX);
    g.sy = clip_reg(model_cfg[REG_STRIDE_Y], SMALL_MASK, STEP_MAX);
    g.kw = clip_reg(model_cfg[REG_KERNEL_W], SMALL_MASK, STEP_MAX);
    g.kh = clip_reg(model_cfg[REG_KERNEL_H], SMALL_MASK, STEP_MAX);
    g.ow = (g.iw - 1) / g.sx + 1;
    g.oh = (g.ih - 1) / g.sy + 1;
    return g;
  endfunction

  function automatic logic [15:0] map_addr(input int unsigned x, input int unsigned y,
                                           input int unsigned ch);
    return 16'((y * MAP_W + x) * MAP_CH + ch);
  endfunction

  function automatic pool_result_t pool_window_average(input logic [POS_W-1:0] px,
                                                       input logic [POS_W-1:0] py,
                                                       input logic [CH_W-1:0] ch);
    pool_result_t r;
    pool_geom_t g;
    int unsigned ix, iy, kx, ky, d, mag;
    logic [31:0] quot;
    int acc;
    g = model_geom;
    r.average = '0;
    r.status = STATUS_OK;
    if (px >= g.ow || py >= g.oh || ch >= g.nc) begin
      r.status = STATUS_RANGE;
      return r;
    end
    acc = 0;
    for (ky = 0; ky < g.kh; ky++) begin
      iy = py * g.sy + ky;
      if (iy > g.ih - 1) iy = g.ih - 1;
      for (kx = 0; kx < g.kw; kx++) begin
        ix = px * g.sx + kx;
        if (ix > g.iw - 1) ix = g.iw - 1;
        acc = acc + $signed(pix_mem[map_addr(ix, iy, ch)]);
      end
    end
    d = g.kw * g.kh;
    mag = (acc < 0) ? -acc : acc;
    // round half away from zero on the magnitude
    quot = (2 * mag + d) / (2 * d);
    r.average = (acc < 0) ? -quot[15:0] : quot[15:0];
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(1, 12));
  endfunction

  function automatic logic [CFG_W-1:0] rand_small(input int unsigned hi);
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom);
    return CFG_W'($urandom_range(1, hi));
  endfunction

  task automatic push_store(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] v);
    stored_flag[map_addr(x, y, ch)] = 1'b1;
    item_queue.push_back('{MODE_STORE, x, y, ch, v});
  endtask

  // Precede an in-range query with stores for any window tap not yet written.
  task automatic push_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] junk);
    pool_geom_t g;
    int unsigned ix, iy, kx, ky;
    g = model_geom;
    if (px < g.ow && py < g.oh && ch < g.nc) begin
      for (ky = 0; ky < g.kh; ky++) begin
        iy = py * g.sy + ky;
        if (iy > g.ih - 1) iy = g.ih - 1;
        for (kx = 0; kx < g.kw; kx++) begin
          ix = px * g.sx + kx;
          if (ix > g.iw - 1) ix = g.iw - 1;
          if (!stored_flag[map_addr(ix, iy, ch)])
            push_store(POS_W'(ix), POS_W'(iy), ch, rand_sample());
        end
      end
    end
    item_queue.push_back('{MODE_QUERY, px, py, ch, junk});
  endtask

  task automatic gen_random(input int n);
    int k, pick;
    pool_geom_t g;
    g = model_geom;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_query(POS_W'($urandom_range(0, g.ow - 1)), POS_W'($urandom_range(0, g.oh - 1)),
                   CH_W'($urandom_range(0, g.nc - 1)), 16'($urandom));
      end else if (pick < 65) begin
        push_query(POS_W'($urandom), POS_W'($urandom), CH_W'($urandom), 16'($urandom));
      end else if (pick < 90) begin
        push_store(POS_W'($urandom_range(0, g.iw - 1)), POS_W'($urandom_range(0, g.ih - 1)),
                   CH_W'($urandom_range(0, g.nc - 1)), rand_sample());
      end else begin
        push_store(POS_W'($urandom), POS_W'($urandom), CH_W'($urandom), rand_sample());
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    model_cfg[idx] = v;
    model_geom = current_geom();
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] sxv,
                              input logic [CFG_W-1:0] syv, input logic [CFG_W-1:0] kwv,
                              input logic [CFG_W-1:0] khv);
    write_reg(REG_IN_WIDTH, w);
    write_reg(REG_IN_HEIGHT, h);
    write_reg(REG_CHANNELS, c);
    write_reg(REG_STRIDE_X, sxv);
    write_reg(REG_STRIDE_Y, syv);
    write_reg(REG_KERNEL_W, kwv);
    write_reg(REG_KERNEL_H, khv);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until every queued beat has gone in and every result is back, then settle.
  task automatic wait_idle();
    do @(posedge clk); while (item_queue.size() != 0 || in_valid || awaited_averages.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      beat_taken = 1'b0;
      if (calm) in_gap = 0;
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        cur = item_queue.pop_front();
        mode <= cur.mode;
        pos_x <= cur.x;
        pos_y <= cur.y;
        channel <= cur.ch;
        sample <= cur.smp;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side back-pressure
  always @(negedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_len = 0;
    end else if (stall_len > 0) begin
      stall_len = stall_len - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 7) == 0) stall_len = $urandom_range(1, 5);
    end
  end

  // monitor: check results, then predict from accepted beats
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_averages.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending: average %0d status %0b",
                   $time, average, status);
        end else begin
          want = awaited_averages.pop_front();
          if (average !== want.average) begin
            mismatches++;
            $display("%0t: average mismatch: expected %0d, actual %0d",
                     $time, want.average, average);
          end
          if (status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0b, actual %0b",
                     $time, want.status, status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        beat_taken = 1'b1;
        if (mode == MODE_STORE)
          pix_mem[map_addr(pos_x, pos_y, channel)] = sample;
        else
          awaited_averages.push_back(pool_window_average(pos_x, pos_y, channel));
      end
    end
  end

  initial begin
    model_geom = current_geom();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed beats at the reset settings (2x2 window, stride 2)
    push_store(6'd0, 6'd0, 4'd0, 16'd1);
    push_store(6'd1, 6'd0, 4'd0, 16'd1);
    push_store(6'd0, 6'd1, 4'd0, 16'd0);
    push_store(6'd1, 6'd1, 4'd0, 16'd0);
    push_query(6'd0, 6'd0, 4'd0, 16'h0000);   // positive half rounds up
    push_store(6'd0, 6'd0, 4'd0, 16'hFFFF);
    push_store(6'd1, 6'd0, 4'd0, 16'hFFFF);
    push_query(6'd0, 6'd0, 4'd0, 16'hFFFF);   // negative half rounds away from zero
    push_store(6'd2, 6'd2, 4'd15, 16'h7FFF);
    push_store(6'd3, 6'd2, 4'd15, 16'h7FFF);
    push_store(6'd2, 6'd3, 4'd15, 16'h7FFF);
    push_store(6'd3, 6'd3, 4'd15, 16'h7FFF);
    push_query(6'd1, 6'd1, 4'd15, 16'h8000);
    push_store(6'd2, 6'd2, 4'd14, 16'h8000);
    push_store(6'd3, 6'd2, 4'd14, 16'h8000);
    push_store(6'd2, 6'd3, 4'd14, 16'h8000);
    push_store(6'd3, 6'd3, 4'd14, 16'h8000);
    push_query(6'd1, 6'd1, 4'd14, 16'h7FFF);
    push_store(6'd63, 6'd63, 4'd15, 16'h8000);
    push_query(6'd31, 6'd31, 4'd15, 16'h5555);
    push_query(6'd32, 6'd0, 4'd0, 16'hAAAA);
    push_query(6'd0, 6'd32, 4'd0, 16'h0000);
    push_query(6'd63, 6'd63, 4'd15, 16'hFFFF);
    wait_idle();

    // single-sample window on a 1x1 map; the unused index must change nothing
    apply_config(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
    write_reg(REG_UNUSED, 7'h55);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_random(30);
    wait_idle();

    // largest map and window, stride 1 so the last windows clamp
    apply_config(7'd64, 7'd64, 7'd16, 7'd1, 7'd1, 7'd16, 7'd16);
    push_query(6'd63, 6'd63, 4'd0, 16'h0000);   // whole window folds onto one sample
    push_query(6'd56, 6'd56, 4'd3, 16'h0000);
    push_query(6'd48, 6'd63, 4'd9, 16'h0000);
    push_query(6'd0, 6'd0, 4'd0, 16'h0000);     // in-range window at the map origin
    wait_idle();

    // zero and oversize register values saturate
    apply_config(7'd0, 7'h7F, 7'h7F, 7'd0, 7'h3F, 7'h60, 7'h5F);
    gen_random(8);
    wait_idle();

    // stride and window larger than the map
    apply_config(7'd5, 7'd3, 7'd3, 7'd16, 7'd16, 7'd16, 7'd16);
    gen_random(20);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 5) calm = 1'b1;
      apply_config(rand_dim(), rand_dim(), rand_small(16), rand_small(6), rand_small(6),
                   rand_small(4), rand_small(4));
      gen_random(8);
      if (ph == 2) wait_idle();
      gen_random(8);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
